@@ hdl/hte_pkg.sv @@
// shared constants and codes for the header table size eviction block
package hte_pkg;

  localparam int FUNC_W  = 2;
  localparam int LEN_W   = 16;
  localparam int TAG_W   = 16;
  localparam int SIZE_W  = 16;
  localparam int STAT_W  = 2;
  localparam int SLOT_OW = 11;
  localparam int CNT_OW  = 12;
  localparam int ELEM_W  = 18;

  localparam int DEF_RING_DEPTH     = 2048;
  localparam int DEF_ENTRY_OVERHEAD = 32;
  localparam logic [SIZE_W-1:0] RESET_LIMIT = 16'd4096;

  localparam logic [FUNC_W-1:0] FN_ADD      = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SET_SIZE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SET_MAX  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK            = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABOVE_MAX     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_REFLECTED = 2'd2;

endpackage

@@ hdl/hte_if.sv @@
// request and response channel interfaces
interface hte_req_if;
  import hte_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [LEN_W-1:0]    key_length;
  logic [LEN_W-1:0]    value_length;
  logic [TAG_W-1:0]    entry_tag;
  logic [SIZE_W-1:0]   new_size;

  modport source (output valid, func, key_length, value_length, entry_tag, new_size,
                  input ready);
  modport sink (input valid, func, key_length, value_length, entry_tag, new_size,
                output ready);
endinterface

interface hte_rsp_if;
  import hte_pkg::*;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic                entry_added;
  logic [SLOT_OW-1:0]  insert_slot;
  logic [CNT_OW-1:0]   evicted_count;
  logic [CNT_OW-1:0]   entry_count;
  logic [SIZE_W-1:0]   bytes_used;

  modport source (output valid, status, entry_added, insert_slot, evicted_count,
                  entry_count, bytes_used, input ready);
  modport sink (input valid, status, entry_added, insert_slot, evicted_count,
                entry_count, bytes_used, output ready);
endinterface

@@ hdl/hte_ring_mem.sv @@
// ring memory of entry sizes and tags, one write port and one registered read port
module hte_ring_mem #(
  parameter int DEPTH  = hte_pkg::DEF_RING_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [hte_pkg::ELEM_W-1:0]  wr_size,
  input  logic [hte_pkg::TAG_W-1:0]   wr_tag,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [hte_pkg::ELEM_W-1:0]  rd_size
);
  import hte_pkg::*;

  logic [ELEM_W-1:0] size_mem [DEPTH];
  logic [TAG_W-1:0]  tag_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      size_mem[wr_addr] <= wr_size;
      tag_mem[wr_addr]  <= wr_tag;
    end
    if (rd_en) begin
      rd_size <= size_mem[rd_addr];
    end
  end

endmodule

@@ hdl/header_table_size_eviction_core.sv @@
// top level: dynamic header table accounting with oldest-first eviction
// sequence: a taken request is planned in S_PLAN; an eviction check runs S_TEST, with S_EVICT
//   after each memory read of the oldest entry, and S_STORE when an add stores its entry;
//   S_DONE registers the response, and a response still waiting holds the core there
// throughput: one item at a time; the next request is taken once the response is registered
// reset: synchronous, clears entry count, bytes used and oldest pointer, both limits return to 4096; ring memory kept
module header_table_size_eviction_core #(
  parameter int RING_DEPTH     = hte_pkg::DEF_RING_DEPTH,
  parameter int ENTRY_OVERHEAD = hte_pkg::DEF_ENTRY_OVERHEAD
) (
  input  logic clk,
  input  logic rst,
  hte_req_if.sink   req,
  hte_rsp_if.source rsp
);
  import hte_pkg::*;

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_PLAN, S_TEST, S_EVICT, S_STORE, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    K_FIT, K_ALL, K_DOWN
  } kind_t;

  state_t              state;
  kind_t               kind;
  logic [FUNC_W-1:0]   func;
  logic [ELEM_W-1:0]   elem;
  logic [TAG_W-1:0]    tag;
  logic [SIZE_W-1:0]   nsize;
  logic [SLOT_W-1:0]   oldest;
  logic [CNT_W-1:0]    held;
  logic [SIZE_W-1:0]   used;
  logic [SIZE_W-1:0]   cur_limit;
  logic [SIZE_W-1:0]   max_limit;
  logic [STAT_W-1:0]   status;
  logic                added;
  logic [SLOT_W-1:0]   slot;
  logic [CNT_W-1:0]    evicted;

  logic                rsp_valid;
  logic [STAT_W-1:0]   rsp_status;
  logic                rsp_added;
  logic [SLOT_OW-1:0]  rsp_slot;
  logic [CNT_OW-1:0]   rsp_evicted;
  logic [CNT_OW-1:0]   rsp_count;
  logic [SIZE_W-1:0]   rsp_used;

  logic [ELEM_W-1:0]   rd_size;
  logic                need_evict;
  logic                fit_over;
  logic                ring_full;
  logic [ELEM_W:0]     fit_sum;
  logic [SUM_W-1:0]    slot_sum;
  logic [SLOT_W-1:0]   slot_next;
  logic [SLOT_W-1:0]   oldest_next;
  logic [SIZE_W-1:0]   used_evict;
  logic [ELEM_W-1:0]   elem_next;
  logic [SLOT_W+SLOT_OW-1:0] slot_ext;
  logic [CNT_W+CNT_OW-1:0]   evicted_ext;
  logic [CNT_W+CNT_OW-1:0]   held_ext;

  // eviction decision for the current step
  always_comb begin
    fit_sum   = (ELEM_W+1)'(used) + (ELEM_W+1)'(elem);
    fit_over  = fit_sum > (ELEM_W+1)'(cur_limit);
    ring_full = held == CNT_W'(RING_DEPTH);
    need_evict = 1'b0;
    if (held != '0) begin
      unique case (kind)
        K_FIT:   need_evict = fit_over || ring_full;
        K_ALL:   need_evict = 1'b1;
        K_DOWN:  need_evict = used > nsize;
        default: need_evict = 1'b0;
      endcase
    end
  end

  // ring arithmetic
  always_comb begin
    slot_sum = SUM_W'(oldest) + SUM_W'(held);
    if (slot_sum >= SUM_W'(RING_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(RING_DEPTH);
    end
    slot_next   = slot_sum[SLOT_W-1:0];
    oldest_next = (oldest == SLOT_W'(RING_DEPTH - 1)) ? '0 : oldest + SLOT_W'(1);
    used_evict  = (rd_size > ELEM_W'(used)) ? '0 : used - rd_size[SIZE_W-1:0];
    elem_next   = ELEM_W'(req.key_length) + ELEM_W'(req.value_length)
                  + ELEM_W'(ENTRY_OVERHEAD);
    slot_ext    = {{SLOT_OW{1'b0}}, slot};
    evicted_ext = {{CNT_OW{1'b0}}, evicted};
    held_ext    = {{CNT_OW{1'b0}}, held};
  end

  hte_ring_mem #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (SLOT_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (state == S_STORE),
    .wr_addr (slot_next),
    .wr_size (elem),
    .wr_tag  (tag),
    .rd_en   (state == S_TEST && need_evict),
    .rd_addr (oldest),
    .rd_size (rd_size)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kind      <= K_FIT;
      oldest    <= '0;
      held      <= '0;
      used      <= '0;
      cur_limit <= RESET_LIMIT;
      max_limit <= RESET_LIMIT;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            func    <= req.func;
            elem    <= elem_next;
            tag     <= req.entry_tag;
            nsize   <= req.new_size;
            status  <= ST_OK;
            added   <= 1'b0;
            slot    <= '0;
            evicted <= '0;
            state   <= S_PLAN;
          end
        end
        S_PLAN: begin
          state <= S_DONE;
          case (func)
            FN_ADD: begin
              if (cur_limit > max_limit) begin
                status <= ST_NOT_REFLECTED;
              end else if (elem > ELEM_W'(cur_limit)) begin
                kind  <= K_ALL;
                state <= S_TEST;
              end else begin
                kind  <= K_FIT;
                state <= S_TEST;
              end
            end
            FN_SET_SIZE: begin
              if (nsize != cur_limit) begin
                if (nsize > max_limit) begin
                  status <= ST_ABOVE_MAX;
                end else begin
                  cur_limit <= nsize;
                  kind      <= K_DOWN;
                  state     <= S_TEST;
                end
              end
            end
            FN_SET_MAX: begin
              if (nsize != max_limit) begin
                max_limit <= nsize;
                kind      <= K_DOWN;
                state     <= S_TEST;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_TEST: begin
          if (need_evict) begin
            state <= S_EVICT;
          end else if (kind == K_FIT) begin
            state <= S_STORE;
          end else begin
            state <= S_DONE;
          end
        end
        S_EVICT: begin
          used    <= used_evict;
          oldest  <= oldest_next;
          held    <= held - CNT_W'(1);
          evicted <= evicted + CNT_W'(1);
          state   <= S_TEST;
        end
        S_STORE: begin
          slot  <= slot_next;
          held  <= held + CNT_W'(1);
          used  <= used + elem[SIZE_W-1:0];
          added <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid   <= 1'b1;
            rsp_status  <= status;
            rsp_added   <= added;
            rsp_slot    <= slot_ext[SLOT_OW-1:0];
            rsp_evicted <= evicted_ext[CNT_OW-1:0];
            rsp_count   <= held_ext[CNT_OW-1:0];
            rsp_used    <= used;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.entry_added   = rsp_added;
  assign rsp.insert_slot   = rsp_slot;
  assign rsp.evicted_count = rsp_evicted;
  assign rsp.entry_count   = rsp_count;
  assign rsp.bytes_used    = rsp_used;

  // occupancy never exceeds the ring
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(RING_DEPTH))
    else $error("held count above ring depth");

  // an empty table accounts no bytes
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    held == '0 |-> used == '0)
    else $error("bytes in use with no entries held");

  // oldest pointer stays inside the ring
  a_oldest_bound: assert property (@(posedge clk) disable iff (rst)
    oldest <= SLOT_W'(RING_DEPTH - 1))
    else $error("oldest pointer outside ring");

  // each eviction update follows its memory read
  a_evict_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_EVICT |-> $past(state) == S_TEST)
    else $error("eviction without preceding read");

endmodule
